@@ rtl/core/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the streaming hash block.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned LenBytePos = 56;
	localparam logic [7:0]  PadByte    = 8'h80;

	// operation codes on the input stream
	localparam logic OpAbsorb = 1'b0;
	localparam logic OpFinish = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	typedef logic [31:0] word_t;

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t ror32(input word_t x, input int unsigned n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t ssig0(input word_t x);
		ssig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		ssig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

endpackage

@@ rtl/core/sha256_stream_hash.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hash
// Absorbs message bytes into a word memory, compresses each full block and
// pads and emits the digest on a finish transfer.
// ----------------------------------------------------------------------------
// Absorb takes one byte per transfer while idle; a byte that fills a block starts
// compression (load carrying rounds 0-15, rounds 16-63, update), with s_tready
// low. Finish: each pad pass writes 16 pad words, then compresses; one or
// two passes, then eight m_tdata transfers, one per cycle while m_tready is high.
// Throughput: one round per cycle, fed by the block memory's one read per cycle.
// Reset loads InitHash, clears counters and control; the memories need no clear.
module sha256_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast    // word_last
);

	sha256_pkg::state_t state_q, state_d;

	// block memory: 16 words, bytes written in place via byte mask
	logic [31:0] blk_mem [16];
	logic [31:0] blk_rd_s1;
	logic [3:0]  blk_rd_addr;
	logic        blk_we;
	logic [3:0]  blk_wr_addr;
	logic [31:0] blk_wr_data;
	logic [3:0]  blk_wr_be;

	logic [31:0] w_q [16];     // rolling schedule (fixed-place shift taps)
	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  fill_q;
	logic [63:0] byte_cnt_q;
	logic [6:0]  rnd_q;        // load/round/pad counter
	logic        final_q;      // set once a pad block has been written
	logic        extra_q;      // pad needs a second block
	logic [2:0]  emit_q;

	logic acc;
	assign acc = s_tvalid && s_tready;
	assign s_tready = (state_q == sha256_pkg::ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (acc && s_tuser == sha256_pkg::OpFinish) state_d = sha256_pkg::ST_PAD;
				else if (acc && fill_q == 6'd63) state_d = sha256_pkg::ST_LOAD;
			end
			sha256_pkg::ST_PAD: if (rnd_q[3:0] == 4'd15) state_d = sha256_pkg::ST_LOAD;
			sha256_pkg::ST_LOAD: if (rnd_q == 7'd16) state_d = sha256_pkg::ST_ROUND;
			sha256_pkg::ST_ROUND: if (rnd_q == 7'd64) state_d = sha256_pkg::ST_UPDATE;
			sha256_pkg::ST_UPDATE: begin
				if (extra_q) state_d = sha256_pkg::ST_PAD;
				else if (final_q) state_d = sha256_pkg::ST_EMIT;
				else state_d = sha256_pkg::ST_IDLE;
			end
			sha256_pkg::ST_EMIT: if (m_tready && emit_q == 3'd7) state_d = sha256_pkg::ST_IDLE;
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	// pad word for slot rnd_q[3:0]; bytes before the fill point are kept
	logic [31:0] pad_word;
	logic [3:0]  pad_be;
	logic [63:0] bit_cnt;
	assign bit_cnt = {byte_cnt_q[60:0], 3'b000};
	always_comb begin
		logic [5:0] bi;
		for (int k = 0; k < 4; k++) begin
			bi = {rnd_q[3:0], 2'(k)};
			pad_be[3-k] = 1'b0;
			pad_word[31-8*k -: 8] = 8'h00;
			if (extra_q) begin
				// first of two pad blocks: marker and zeros only
				if (bi >= fill_q) pad_be[3-k] = 1'b1;
				if (bi == fill_q && !final_q) pad_word[31-8*k -: 8] = sha256_pkg::PadByte;
			end else begin
				if (bi >= fill_q || final_q) pad_be[3-k] = 1'b1;
				if (bi == fill_q && !final_q) pad_word[31-8*k -: 8] = sha256_pkg::PadByte;
				if (bi >= 6'(sha256_pkg::LenBytePos))
					pad_word[31-8*k -: 8] = bit_cnt[8*(63-int'(bi)) +: 8];
			end
		end
	end

	// memory write port control
	always_comb begin
		blk_we = 1'b0;
		blk_wr_addr = fill_q[5:2];
		blk_wr_data = {4{s_tdata}};
		blk_wr_be = 4'b1000 >> fill_q[1:0];
		if (state_q == sha256_pkg::ST_IDLE && acc && s_tuser == sha256_pkg::OpAbsorb) begin
			blk_we = 1'b1;
		end else if (state_q == sha256_pkg::ST_PAD) begin
			blk_we = 1'b1;
			blk_wr_addr = rnd_q[3:0];
			blk_wr_data = pad_word;
			blk_wr_be = pad_be;
		end
		blk_rd_addr = rnd_q[3:0];
	end

	// block memory, registered read
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++)
			if (blk_we && blk_wr_be[k]) blk_mem[blk_wr_addr][8*k +: 8] <= blk_wr_data[8*k +: 8];
		blk_rd_s1 <= blk_mem[blk_rd_addr];
	end

	// round datapath; the round index trails the counter by one
	logic [31:0] w_cur, t1, t2;
	logic [5:0]  rr;
	assign rr = rnd_q[5:0] - 6'd1;
	always_comb begin
		if (state_q == sha256_pkg::ST_LOAD) w_cur = blk_rd_s1;
		else w_cur = w_q[0] + sha256_pkg::ssig0(w_q[1]) + w_q[9] + sha256_pkg::ssig1(w_q[14]);
		t1 = v_q[7] + sha256_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha256_pkg::RoundConst[rr] + w_cur;
		t2 = sha256_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	logic do_round;
	assign do_round = (state_q == sha256_pkg::ST_LOAD && rnd_q != 7'd0)
		|| state_q == sha256_pkg::ST_ROUND;

	// schedule and working variables
	always_ff @(posedge clk) begin
		if (do_round) begin
			for (int k = 0; k < 15; k++) w_q[k] <= w_q[k+1];
			w_q[15] <= w_cur;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else if (state_q == sha256_pkg::ST_LOAD) begin
			for (int k = 0; k < 8; k++) v_q[k] <= hash_q[k];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
			for (int k = 0; k < 8; k++) hash_q[k] <= sha256_pkg::InitHash[k];
			fill_q <= '0;
			byte_cnt_q <= '0;
			rnd_q <= '0;
			final_q <= 1'b0;
			extra_q <= 1'b0;
			emit_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sha256_pkg::ST_IDLE: begin
					rnd_q <= '0;
					if (acc && s_tuser == sha256_pkg::OpAbsorb) begin
						fill_q <= fill_q + 6'd1;
						byte_cnt_q <= byte_cnt_q + 64'd1;
					end else if (acc) begin
						extra_q <= (fill_q >= 6'(sha256_pkg::LenBytePos));
					end
				end
				sha256_pkg::ST_PAD: begin
					rnd_q <= (rnd_q[3:0] == 4'd15) ? 7'd0 : rnd_q + 7'd1;
					if (rnd_q[3:0] == 4'd15) final_q <= 1'b1;
				end
				sha256_pkg::ST_LOAD: rnd_q <= rnd_q + 7'd1;
				sha256_pkg::ST_ROUND: rnd_q <= rnd_q + 7'd1;
				sha256_pkg::ST_UPDATE: begin
					rnd_q <= '0;
					for (int k = 0; k < 8; k++) hash_q[k] <= hash_q[k] + v_q[k];
					if (extra_q) begin
						// second pad block: zeros, then the length
						extra_q <= 1'b0;
						fill_q <= '0;
					end
					emit_q <= '0;
				end
				sha256_pkg::ST_EMIT: begin
					if (m_tready) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							for (int k = 0; k < 8; k++) hash_q[k] <= sha256_pkg::InitHash[k];
							fill_q <= '0;
							byte_cnt_q <= '0;
							final_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// output stream
	assign m_tvalid = (state_q == sha256_pkg::ST_EMIT);
	assign m_tdata = hash_q[emit_q];
	assign m_tlast = (emit_q == 3'd7);

	// assertions
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken during digest output");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready) else $error("no return to idle");
	a_round_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256_pkg::ST_UPDATE) |-> ($past(rnd_q) == 7'd64))
		else $error("compression ended early");

endmodule

@@ tb/sha256_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hash checker
// Watches both streams, keeps its own hash state, predicts the eight digest
// words of each finish transfer and compares them with the output stream.
// ----------------------------------------------------------------------------
module sha256_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] digest_word
	input  logic        m_tlast,   // word_last
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_item_t;

	digest_item_t         digest_q[$];
	sha256_pkg::word_t    chain[8];
	logic [7:0]           blk[64];
	int unsigned          fill;
	logic [63:0]          msg_len;

	function automatic sha256_pkg::word_t rotr(input sha256_pkg::word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one full compression of blk into chain
	task automatic compress();
		sha256_pkg::word_t w[64];
		sha256_pkg::word_t v[8];
		sha256_pkg::word_t t1, t2;
		for (int r = 0; r < 16; r++)
			w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
		for (int r = 16; r < 64; r++)
			w[r] = w[r-16] + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
				+ w[r-7] + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
		for (int k = 0; k < 8; k++) v[k] = chain[k];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundConst[r] + w[r];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int k = 7; k > 0; k--) v[k] = v[k-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int k = 0; k < 8; k++) chain[k] = chain[k] + v[k];
	endtask

	task automatic restart();
		for (int k = 0; k < 8; k++) chain[k] = sha256_pkg::InitHash[k];
		fill = 0;
		msg_len = '0;
	endtask

	// padding and digest prediction for a finish transfer
	task automatic finish_message();
		logic [63:0] bits;
		int unsigned pos;
		bits = msg_len << 3;
		pos = fill;
		blk[pos++] = sha256_pkg::PadByte;
		if (pos > sha256_pkg::LenBytePos) begin
			while (pos < sha256_pkg::BlockBytes) blk[pos++] = 8'h00;
			compress();
			pos = 0;
		end
		while (pos < sha256_pkg::LenBytePos) blk[pos++] = 8'h00;
		for (int k = 0; k < 8; k++) blk[sha256_pkg::LenBytePos + k] = bits[63 - 8*k -: 8];
		compress();
		for (int k = 0; k < 8; k++) digest_q.push_back('{chain[k], k == 7});
		restart();
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch: %s got %h expected %h", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		digest_item_t exp_item;
		if (!arst_n) begin
			restart();
		end else begin
			// output transfer against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					report("unexpected digest word", m_tdata, 32'h0);
				end else begin
					exp_item = digest_q.pop_front();
					if (m_tdata !== exp_item.word) report("digest_word", m_tdata, exp_item.word);
					if (m_tlast !== exp_item.last)
						report("word_last", 32'(m_tlast), 32'(exp_item.last));
				end
			end
			// input transfer
			if (s_tvalid && s_tready) begin
				if (s_tuser == sha256_pkg::OpFinish) begin
					finish_message();
				end else begin
					blk[fill] = s_tdata;
					msg_len++;
					fill++;
					if (fill == sha256_pkg::BlockBytes) begin
						compress();
						fill = 0;
					end
				end
			end
		end
		pending = digest_q.size();
	end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hash testbench
// Sends directed and random messages (absorb bytes, then a finish) with
// random gaps and output stalls; the checker predicts and compares digests.
// ----------------------------------------------------------------------------
module tb_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = sha256_pkg::OpAbsorb;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	int          fail_count;
	int          pending;
	int          cycle = 0;
	bit          calm = 1'b0;

	localparam int CycleLimit = 400000;

	always #1 clk = ~clk;

	sha256_stream_hash i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	sha256_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// receiver stalls
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 31);
	end

	// watchdog
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// one input transfer, with a random gap first; valid stays high until
	// the next gap so it gets one update per edge
	task automatic send(input logic op, input logic [7:0] value);
		while (!calm && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic message(input int len, input int kind);
		for (int i = 0; i < len; i++)
			case (kind)
				0: send(sha256_pkg::OpAbsorb, 8'h00);
				1: send(sha256_pkg::OpAbsorb, 8'hff);
				default: send(sha256_pkg::OpAbsorb, 8'($urandom_range(255)));
			endcase
		send(sha256_pkg::OpFinish, 8'($urandom_range(255)));
	endtask

	initial begin
		int len;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty message, padding boundaries, a full block, extreme bytes
		message(0, 2);
		message(3, 1);
		message(55, 0);
		// one long stretch with no idling
		calm = 1'b1;
		message(56, 2);
		calm = 1'b0;
		message(70, 1);
		// a few short random messages
		for (int n = 0; n < 4; n++) begin
			len = $urandom_range(8);
			message(len, 2);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/sha256_pkg.sv
rtl/core/sha256_stream_hash.sv
tb/sha256_checker.sv
tb/tb_top.sv
